/* src/sfr_pkg.sv */
// shared types and constants for the stuffed frame receiver
package sfr_pkg;

  localparam logic [7:0] START_MARK  = 8'h5A;
  localparam logic [7:0] ESCAPE_MARK = 8'h5C;

  localparam logic [7:0] BOARD_ADDRESS_RST  = 8'h01;
  localparam logic [7:0] TIMEOUT_RELOAD_RST = 8'd20;

  localparam logic CFG_BOARD_ADDRESS  = 1'b0;
  localparam logic CFG_TIMEOUT_RELOAD = 1'b1;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_ADDR = 4'b0010,
    PH_LEN  = 4'b0100,
    PH_BODY = 4'b1000
  } phase_t;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
    logic       host_busy;
  } item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [8:0] byte_index;
    logic       last_byte;
    logic       frame_good;
  } result_t;

  typedef struct packed {
    logic [7:0] board_address;
    logic [7:0] timeout_reload;
  } cfg_t;

endpackage

/* src/sfr_in_reg.sv */
// input register holding one request until the decoder takes it
module sfr_in_reg import sfr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  item_vld,
  output item_t item
);

  logic  vld_r;
  item_t item_r;

  assign in_ready = !vld_r || advance;
  assign item_vld = vld_r;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

/* src/sfr_decode.sv */
// receive state machine: framing, unstuffing, checksum and idle timer
module sfr_decode import sfr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    advance,
  input  item_t   item,
  input  cfg_t    cfg,
  output logic    res_vld,
  output result_t res
);

  phase_t     phase_r, phase_nxt;
  logic       esc_r, esc_nxt;
  logic [7:0] left_r, left_nxt;
  logic [8:0] wpos_r, wpos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] timer_r, timer_nxt;
  logic [7:0] dec;
  logic       take;

  always_comb begin
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    left_nxt  = left_r;
    wpos_nxt  = wpos_r;
    sum_nxt   = sum_r;
    timer_nxt = timer_r;
    res_vld   = 1'b0;
    res       = '0;
    dec       = item.rx_byte;
    take      = 1'b0;

    if (item.op == OP_TICK) begin
      if (timer_r != 8'd0) begin
        timer_nxt = timer_r - 8'd1;
        if (timer_r == 8'd1) begin
          phase_nxt = PH_HUNT;
        end
      end
    end else if (item.host_busy) begin
      timer_nxt = 8'd0;
      phase_nxt = PH_HUNT;
    end else begin
      timer_nxt = cfg.timeout_reload;
      sum_nxt   = sum_r + item.rx_byte;
      // escape mark survives aborts, cleared only when consumed
      if (esc_r) begin
        dec  = item.rx_byte ^ ESCAPE_MARK;
        take = 1'b1;
      end else begin
        take = (item.rx_byte != ESCAPE_MARK);
      end

      case (phase_r)
        PH_HUNT: begin
          if (item.rx_byte == START_MARK) begin
            phase_nxt = PH_ADDR;
            sum_nxt   = 8'd0;
          end
        end
        PH_ADDR: begin
          if (item.rx_byte == cfg.board_address) begin
            phase_nxt = PH_LEN;
          end else begin
            timer_nxt = 8'd0;
            phase_nxt = PH_HUNT;
          end
        end
        PH_LEN: begin
          esc_nxt = !take;
          if (take) begin
            left_nxt       = dec;
            wpos_nxt       = 9'd1;
            phase_nxt      = PH_BODY;
            res_vld        = 1'b1;
            res.data_byte  = dec;
            res.byte_index = 9'd0;
          end
        end
        PH_BODY: begin
          esc_nxt = !take;
          if (take) begin
            // length zero wraps to 256 content bytes
            left_nxt       = left_r - 8'd1;
            wpos_nxt       = wpos_r + 9'd1;
            res_vld        = 1'b1;
            res.data_byte  = dec;
            res.byte_index = wpos_r;
            if (left_r == 8'd1) begin
              res.last_byte  = 1'b1;
              res.frame_good = (sum_nxt == 8'd0);
              timer_nxt      = 8'd0;
              phase_nxt      = PH_HUNT;
            end
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      esc_r   <= 1'b0;
      left_r  <= 8'd0;
      wpos_r  <= 9'd0;
      sum_r   <= 8'd0;
      timer_r <= 8'd0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
      left_r  <= left_nxt;
      wpos_r  <= wpos_nxt;
      sum_r   <= sum_nxt;
      timer_r <= timer_nxt;
    end
  end

endmodule

/* src/sfr_out_reg.sv */
// result register towards the output channel
module sfr_out_reg import sfr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  logic    res_vld,
  input  result_t res,
  output logic    free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    vld_r;
  result_t res_r;

  assign free      = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= res_vld;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_vld) begin
      res_r <= res;
    end
  end

endmodule

/* src/stuffed_frame_receiver_top.sv */
// path: an accepted request waits in the input register, is decoded and its result is loaded into the result register
// throughput: one request per cycle, held back only when the result register is stalled
// a byte, tick or dropped byte that gives no result still takes a slot in the decoder
// reset (synchronous, rst_n low): hunting for start, counters, sum and timer cleared,
// board address 1 and timeout reload 20
module stuffed_frame_receiver_top import sfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [7:0] in_rx_byte,
  input  logic       in_host_busy,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_byte,
  output logic [8:0] out_byte_index,
  output logic       out_last_byte,
  output logic       out_frame_good,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t    cfg_r;
  item_t   in_item, item;
  logic    item_vld, advance, free, res_vld;
  result_t res, out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.board_address  <= BOARD_ADDRESS_RST;
      cfg_r.timeout_reload <= TIMEOUT_RELOAD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BOARD_ADDRESS:  cfg_r.board_address  <= cfg_data;
        CFG_TIMEOUT_RELOAD: cfg_r.timeout_reload <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_item.op        = in_op;
  assign in_item.rx_byte   = in_rx_byte;
  assign in_item.host_busy = in_host_busy;

  assign advance = item_vld && free;

  sfr_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (advance),
    .item_vld (item_vld),
    .item     (item)
  );

  sfr_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .cfg     (cfg_r),
    .res_vld (res_vld),
    .res     (res)
  );

  sfr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res_vld   (res_vld),
    .res       (res),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_data_byte  = out_res.data_byte;
  assign out_byte_index = out_res.byte_index;
  assign out_last_byte  = out_res.last_byte;
  assign out_frame_good = out_res.frame_good;

endmodule

/* test/stuffed_frame_receiver_top_tb.sv */
// self-checking testbench for the stuffed frame receiver: directed and random frames
module stuffed_frame_receiver_top_tb;
  import sfr_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;

  class frame_scoreboard;
    logic [7:0] board_address  = BOARD_ADDRESS_RST;
    logic [7:0] timeout_reload = TIMEOUT_RELOAD_RST;
    phase_t     phase          = PH_HUNT;
    logic       escape_pending = 1'b0;
    logic [7:0] bytes_left     = '0;
    logic [8:0] write_position = '0;
    logic [7:0] running_sum    = '0;
    logic [7:0] idle_timer     = '0;
    result_t    decoded_due[$];
    int         mismatches     = 0;

    function void write_register(logic idx, logic [7:0] value);
      if (idx == CFG_BOARD_ADDRESS) begin
        board_address = value;
      end else begin
        timeout_reload = value;
      end
    endfunction

    function void note_request(item_t it);
      logic [7:0] b;
      result_t    r;
      b = it.rx_byte;
      if (it.op == OP_TICK) begin
        if (idle_timer != 0) begin
          idle_timer--;
          if (idle_timer == 0) phase = PH_HUNT;
        end
        return;
      end
      if (it.host_busy) begin
        idle_timer = '0;
        phase      = PH_HUNT;
        return;
      end
      idle_timer  = timeout_reload;
      running_sum = running_sum + b;
      case (phase)
        PH_HUNT: begin
          if (b == START_MARK) begin
            phase       = PH_ADDR;
            running_sum = '0;
          end
        end
        PH_ADDR: begin
          if (b == board_address) begin
            phase = PH_LEN;
          end else begin
            idle_timer = '0;
            phase      = PH_HUNT;
          end
        end
        default: begin
          // escape mark only clears once a following byte consumes it
          if (escape_pending) begin
            escape_pending = 1'b0;
            b = b ^ ESCAPE_MARK;
          end else if (b == ESCAPE_MARK) begin
            escape_pending = 1'b1;
            return;
          end
          r = '0;
          r.data_byte = b;
          if (phase == PH_LEN) begin
            bytes_left     = b;
            write_position = 9'd1;
            phase          = PH_BODY;
          end else begin
            r.byte_index   = write_position;
            write_position = write_position + 9'd1;
            bytes_left     = bytes_left - 8'd1;
            if (bytes_left == 0) begin
              r.last_byte  = 1'b1;
              r.frame_good = (running_sum == 0);
              idle_timer   = '0;
              phase        = PH_HUNT;
            end
          end
          decoded_due.push_back(r);
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (decoded_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual data %h index %0d last %b good %b",
                 $time, got.data_byte, got.byte_index, got.last_byte, got.frame_good);
        return;
      end
      want = decoded_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (got.data_byte !== want.data_byte)
          $display("%0t: data_byte expected %h actual %h", $time, want.data_byte, got.data_byte);
        if (got.byte_index !== want.byte_index)
          $display("%0t: byte_index expected %0d actual %0d", $time, want.byte_index,
                   got.byte_index);
        if (got.last_byte !== want.last_byte)
          $display("%0t: last_byte expected %b actual %b", $time, want.last_byte, got.last_byte);
        if (got.frame_good !== want.frame_good)
          $display("%0t: frame_good expected %b actual %b", $time, want.frame_good,
                   got.frame_good);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_ready;
  logic       in_op        = OP_BYTE;
  logic [7:0] in_rx_byte   = '0;
  logic       in_host_busy = 1'b0;
  logic       out_valid;
  logic       out_ready    = 1'b0;
  logic [7:0] out_data_byte;
  logic [8:0] out_byte_index;
  logic       out_last_byte;
  logic       out_frame_good;
  logic       cfg_valid    = 1'b0;
  logic       cfg_ready;
  logic       cfg_index    = CFG_BOARD_ADDRESS;
  logic [7:0] cfg_data     = '0;

  frame_scoreboard frame_check = new;
  int unsigned     in_idle_pct   = 0;
  int unsigned     out_idle_pct  = 50;
  int unsigned     requests_sent = 0;
  int unsigned     cycle_count   = 0;
  logic [7:0]      line_bytes[$];
  logic [7:0]      line_sum;

  stuffed_frame_receiver_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_rx_byte     (in_rx_byte),
    .in_host_busy   (in_host_busy),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_byte  (out_data_byte),
    .out_byte_index (out_byte_index),
    .out_last_byte  (out_last_byte),
    .out_frame_good (out_frame_good),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("stuffed_frame_receiver_top_tb: FAIL");
      $finish;
    end
  end

  // result side: check on handshake, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      frame_check.check_result(result_t'{out_data_byte, out_byte_index, out_last_byte,
                                         out_frame_good});
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  task automatic send_item(logic op, logic [7:0] b, logic busy);
    item_t it;
    it.op        = op;
    it.rx_byte   = b;
    it.host_busy = busy;
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid     <= 1'b1;
    in_op        <= it.op;
    in_rx_byte   <= it.rx_byte;
    in_host_busy <= it.host_busy;
    do @(posedge clk); while (!in_ready);
    frame_check.note_request(it);
    requests_sent++;
  endtask

  task automatic send_line(bit noisy);
    foreach (line_bytes[i]) begin
      if (noisy && $urandom_range(99) < 4)
        send_item(OP_TICK, 8'($urandom), 1'($urandom));
      if (noisy && $urandom_range(299) == 0)
        send_item(OP_BYTE, 8'($urandom), 1'b1);
      send_item(OP_BYTE, line_bytes[i], 1'b0);
    end
  endtask

  function automatic void push_raw(logic [7:0] b);
    line_bytes.push_back(b);
    line_sum = line_sum + b;
  endfunction

  function automatic void push_coded(logic [7:0] v);
    if (v == ESCAPE_MARK || $urandom_range(7) == 0) begin
      push_raw(ESCAPE_MARK);
      push_raw(v ^ ESCAPE_MARK);
    end else begin
      push_raw(v);
    end
  endfunction

  // length zero means 256 content bytes; the last content byte is the checksum
  task automatic send_frame(logic [7:0] addr, logic [7:0] len, bit aim_good, bit noisy);
    int unsigned count;
    logic [7:0]  v;
    line_bytes = {START_MARK};
    line_sum   = '0;
    push_raw(addr);
    push_coded(len);
    count = (len == 0) ? 256 : len;
    for (int i = 1; i < count; i++) begin
      case ($urandom_range(7))
        0:       v = START_MARK;
        1:       v = ESCAPE_MARK;
        default: v = 8'($urandom);
      endcase
      push_coded(v);
    end
    v = 8'(0 - line_sum);
    if (!aim_good) begin
      push_coded(8'($urandom));
    end else if (v == ESCAPE_MARK) begin
      // raw escape plus zero still sums to the needed value
      push_raw(ESCAPE_MARK);
      push_raw(8'h00);
    end else begin
      push_raw(v);
    end
    send_line(noisy);
  endtask

  task automatic send_noise();
    int unsigned n;
    if ($urandom_range(2) == 0) begin
      n = $urandom_range(1, 25);
      repeat (n) send_item(OP_TICK, 8'($urandom), 1'($urandom));
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) send_item(OP_BYTE, 8'($urandom), $urandom_range(9) == 0);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (frame_check.decoded_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    frame_check.write_register(idx, value);
  endtask

  task automatic run_phase(logic [7:0] addr, logic [7:0] reload, int unsigned sender_idle,
                           int unsigned receiver_idle, bit with_long_frame);
    int unsigned stop_at;
    write_cfg(CFG_BOARD_ADDRESS, addr);
    write_cfg(CFG_TIMEOUT_RELOAD, reload);
    cfg_valid    <= 1'b0;
    in_idle_pct  = sender_idle;
    out_idle_pct = receiver_idle;
    if (with_long_frame) send_frame(frame_check.board_address, 8'd0, 1'b1, 1'b0);
    stop_at = requests_sent + 360;
    while (requests_sent < stop_at) begin
      if ($urandom_range(4) == 0) begin
        send_noise();
      end else begin
        send_frame(($urandom_range(9) == 0) ? 8'($urandom) : frame_check.board_address,
                   ($urandom_range(99) == 0) ? 8'd0 : 8'($urandom_range(1, 10)),
                   $urandom_range(6) != 0, 1'b1);
      end
    end
    settle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // tick while the timer is already idle
    send_item(OP_TICK, 8'h00, 1'b0);
    // shortest good frame
    line_bytes = {START_MARK, 8'h01, 8'h01, 8'hFE};
    send_line(1'b0);
    // escape pending in the length byte survives a busy abort
    line_bytes = {START_MARK, 8'h01, ESCAPE_MARK};
    send_line(1'b0);
    send_item(OP_BYTE, 8'hFF, 1'b1);
    send_item(OP_TICK, START_MARK, 1'b1);
    line_bytes = {START_MARK, 8'h01, 8'h5D, 8'h00};
    send_line(1'b0);
    // wrong address
    line_bytes = {START_MARK, 8'h02};
    send_line(1'b0);
    // start mark as content and an escaped content byte
    line_bytes = {START_MARK, 8'h01, 8'h03, START_MARK, ESCAPE_MARK, 8'h06, 8'h40};
    send_line(1'b0);
    // bad checksum at the top of the byte range
    line_bytes = {START_MARK, 8'h01, 8'h01, 8'hFF};
    send_line(1'b0);
    settle();

    run_phase(8'h00, 8'd1, 33, 75, 1'b1);
    run_phase(8'hFF, 8'd255, 75, 33, 1'b0);
    run_phase(ESCAPE_MARK, 8'd0, 0, 0, 1'b1);

    if (frame_check.mismatches == 0) begin
      $display("stuffed_frame_receiver_top_tb: PASS");
    end else begin
      $display("stuffed_frame_receiver_top_tb: FAIL");
    end
    $finish;
  end

endmodule

/* stuffed_frame_receiver_top.f */
src/sfr_pkg.sv
src/sfr_in_reg.sv
src/sfr_decode.sv
src/sfr_out_reg.sv
src/stuffed_frame_receiver_top.sv
test/stuffed_frame_receiver_top_tb.sv
